FILE: src/tdps_pkg.sv
// Shared constants and types for the threaded DMA program sequencer.
// Depends on nothing; every other source file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tdps_pkg;

  // Number of hardware threads, 1 to 8.
  localparam int THREAD_COUNT  = 6;
  // Program store depth in words; a power of two from 16 to 8192.
  localparam int PROGRAM_DEPTH = 256;

  localparam int TID_W   = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int PROG_AW = $clog2(PROGRAM_DEPTH);

  localparam int WORD_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int TARGET_W = 15;
  localparam int COUNT_W  = 8;
  localparam int SERVED_W = 3;

  typedef logic [TID_W-1:0]   tid_t;
  typedef logic [PROG_AW-1:0] prog_addr_t;
  typedef logic [WORD_W-1:0]  word_t;

  // Input item kinds.
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Instruction opcodes in bits 31..30.
  typedef enum logic [1:0] {
    OP_SET_R0 = 2'd0,
    OP_SET_R1 = 2'd1,
    OP_LOAD   = 2'd2,
    OP_SNOOP  = 2'd3
  } opcode_t;

endpackage

`default_nettype wire

FILE: src/tdps_if.sv
// Valid/ready channel interfaces for the sequencer's item and result streams.
// Depends on tdps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tdps_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [tdps_pkg::WORD_W-1:0]  snoop_addr;
  logic [tdps_pkg::INDEX_W-1:0] prog_index;
  logic [tdps_pkg::WORD_W-1:0]  prog_word;

  modport source (output valid, mode, snoop_addr, prog_index, prog_word, input ready);
  modport sink   (input valid, mode, snoop_addr, prog_index, prog_word, output ready);
endinterface

interface tdps_out_if;
  logic                          valid;
  logic                          ready;
  logic [tdps_pkg::SERVED_W-1:0] thread_served;
  logic [tdps_pkg::WORD_W-1:0]   next_pc;
  logic                          snoop_hit;
  logic                          load_request;
  logic [tdps_pkg::WORD_W-1:0]   load_main_addr;
  logic [tdps_pkg::WORD_W-1:0]   load_scratch_addr;
  logic [tdps_pkg::COUNT_W-1:0]  load_words;

  modport source (output valid, thread_served, next_pc, snoop_hit, load_request,
                  load_main_addr, load_scratch_addr, load_words, input ready);
  modport sink   (input valid, thread_served, next_pc, snoop_hit, load_request,
                  load_main_addr, load_scratch_addr, load_words, output ready);
endinterface

`default_nettype wire

FILE: src/threaded_dma_program_sequencer.sv
// Threaded DMA program sequencer: round-robin threads, program store, snoop branch.
// The store is read at the edge that accepts a tick, and the step executes into the output register
// when the execute stage advances; a stalled output holds it. One item per cycle unless the output
// stalls; a program write takes the store write port and gives no result.
// Synchronous active-low reset clears the thread pointer and all per-thread state; the
// program store is not cleared and must be written before it is fetched. Uses tdps_pkg, tdps_if.
`timescale 1ns / 1ps
`default_nettype none

module threaded_dma_program_sequencer (
  input  wire            clk,
  input  wire            rst_n,
  tdps_in_if.sink        in_ch,
  tdps_out_if.source     out_ch
);

  localparam int TC = tdps_pkg::THREAD_COUNT;

  // Thread pointer and per-thread state.
  tdps_pkg::tid_t              current_thread_r, current_thread_nxt;
  tdps_pkg::word_t             thread_pc_r   [TC];
  tdps_pkg::word_t             addr_reg0_r   [TC];
  tdps_pkg::word_t             addr_reg1_r   [TC];
  logic [tdps_pkg::TARGET_W-1:0] target0_r   [TC];
  logic [tdps_pkg::TARGET_W-1:0] target1_r   [TC];
  logic [TC-1:0]               snoop_armed_r;

  // Program store.
  tdps_pkg::word_t             prog_mem [tdps_pkg::PROGRAM_DEPTH];
  tdps_pkg::word_t             inst_r;

  // Execute stage.
  logic                        s1_valid_r;
  tdps_pkg::tid_t              s1_tid_r;
  tdps_pkg::word_t             s1_snoop_r;

  // Output register.
  logic                        out_valid_r;
  logic [tdps_pkg::SERVED_W-1:0] out_thread_r;
  tdps_pkg::word_t             out_pc_r;
  logic                        out_hit_r;
  logic                        out_load_r;
  tdps_pkg::word_t             out_main_r;
  tdps_pkg::word_t             out_scratch_r;
  logic [tdps_pkg::COUNT_W-1:0] out_words_r;

  logic                        in_ready;
  logic                        in_fire;
  logic                        tick_fire;
  logic                        write_fire;
  logic                        s1_adv;

  tdps_pkg::tid_t              next_tid;
  tdps_pkg::word_t             pc_fetch;
  tdps_pkg::prog_addr_t        rd_idx;
  tdps_pkg::prog_addr_t        wr_idx;
  tdps_pkg::word_t             prog_idx_ext;

  // Execute results.
  tdps_pkg::opcode_t           ex_op;
  tdps_pkg::word_t             ex_pc;
  tdps_pkg::word_t             ex_pc_new;
  tdps_pkg::word_t             ex_r0;
  tdps_pkg::word_t             ex_r1;
  logic                        ex_armed;
  logic                        ex_hit;
  logic                        ex_hit1;
  logic                        ex_hit0;
  logic                        ex_load;
  logic                        ex_wr_r0;
  logic                        ex_wr_r1;
  logic                        ex_arm;

  assign s1_adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready   = !s1_valid_r || s1_adv;
  assign in_ch.ready = in_ready;
  assign in_fire    = in_ch.valid && in_ready;
  assign tick_fire  = in_fire && (in_ch.mode == tdps_pkg::MODE_TICK);
  assign write_fire = in_fire && (in_ch.mode == tdps_pkg::MODE_WRITE);

  // The pointer advances before the selected thread runs.
  assign next_tid = (current_thread_r == tdps_pkg::tid_t'(TC - 1)) ? '0
                  : tdps_pkg::tid_t'(current_thread_r + 1'b1);

  always_comb begin
    current_thread_nxt = current_thread_r;
    if (tick_fire) begin
      current_thread_nxt = next_tid;
    end
  end

  // The fetch for a new tick uses the pc that the execute stage is committing
  // this cycle when both belong to the same thread.
  assign pc_fetch = (s1_adv && (s1_tid_r == next_tid)) ? ex_pc_new : thread_pc_r[next_tid];
  assign rd_idx   = pc_fetch[tdps_pkg::PROG_AW+1:2];

  assign prog_idx_ext = tdps_pkg::word_t'(in_ch.prog_index);
  assign wr_idx       = prog_idx_ext[tdps_pkg::PROG_AW-1:0];

  always_ff @(posedge clk) begin
    if (write_fire) begin
      prog_mem[wr_idx] <= in_ch.prog_word;
    end
    if (tick_fire) begin
      inst_r <= prog_mem[rd_idx];
    end
  end

  // Execute the step of the thread held in the execute stage.
  always_comb begin
    ex_op     = tdps_pkg::opcode_t'(inst_r[31:30]);
    ex_pc     = thread_pc_r[s1_tid_r];
    ex_r0     = addr_reg0_r[s1_tid_r];
    ex_r1     = addr_reg1_r[s1_tid_r];
    ex_armed  = snoop_armed_r[s1_tid_r];
    ex_hit1   = (s1_snoop_r == ex_r1);
    ex_hit0   = (s1_snoop_r == ex_r0);
    ex_hit    = 1'b0;
    ex_load   = 1'b0;
    ex_wr_r0  = 1'b0;
    ex_wr_r1  = 1'b0;
    ex_arm    = 1'b0;
    ex_pc_new = ex_pc;
    if (ex_armed) begin
      // Register 1 takes priority when both addresses match.
      if (ex_hit1) begin
        ex_hit    = 1'b1;
        ex_pc_new = tdps_pkg::word_t'(target1_r[s1_tid_r]);
      end else if (ex_hit0) begin
        ex_hit    = 1'b1;
        ex_pc_new = tdps_pkg::word_t'(target0_r[s1_tid_r]);
      end
    end else begin
      ex_pc_new = ex_pc + 32'd4;
      case (ex_op)
        tdps_pkg::OP_SET_R0: ex_wr_r0 = 1'b1;
        tdps_pkg::OP_SET_R1: ex_wr_r1 = 1'b1;
        tdps_pkg::OP_LOAD:   ex_load  = 1'b1;
        tdps_pkg::OP_SNOOP:  ex_arm   = 1'b1;
        default:             ex_arm   = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_thread_r <= '0;
      snoop_armed_r    <= '0;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      for (int i = 0; i < TC; i++) begin
        thread_pc_r[i] <= '0;
        addr_reg0_r[i] <= '0;
        addr_reg1_r[i] <= '0;
        target0_r[i]   <= '0;
        target1_r[i]   <= '0;
      end
    end else begin
      current_thread_r <= current_thread_nxt;

      if (tick_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        thread_pc_r[s1_tid_r] <= ex_pc_new;
        if (ex_wr_r0) begin
          addr_reg0_r[s1_tid_r] <= {inst_r[29:0], 2'b00};
        end
        if (ex_wr_r1) begin
          addr_reg1_r[s1_tid_r] <= {inst_r[29:0], 2'b00};
        end
        if (ex_arm) begin
          target0_r[s1_tid_r]     <= inst_r[29:15];
          target1_r[s1_tid_r]     <= inst_r[14:0];
          snoop_armed_r[s1_tid_r] <= 1'b1;
        end else if (ex_hit) begin
          snoop_armed_r[s1_tid_r] <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_tid_r   <= next_tid;
      s1_snoop_r <= in_ch.snoop_addr;
    end
    if (s1_adv) begin
      out_thread_r  <= tdps_pkg::SERVED_W'(s1_tid_r);
      out_pc_r      <= ex_pc_new;
      out_hit_r     <= ex_hit;
      out_load_r    <= ex_load;
      out_main_r    <= ex_load ? ex_r0 : '0;
      out_scratch_r <= ex_load ? ex_r1 : '0;
      out_words_r   <= ex_load ? inst_r[tdps_pkg::COUNT_W-1:0] : '0;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.thread_served     = out_thread_r;
  assign out_ch.next_pc           = out_pc_r;
  assign out_ch.snoop_hit         = out_hit_r;
  assign out_ch.load_request      = out_load_r;
  assign out_ch.load_main_addr    = out_main_r;
  assign out_ch.load_scratch_addr = out_scratch_r;
  assign out_ch.load_words        = out_words_r;

  // A branch and a load never come from the same step.
  a_hit_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_load_r))
    else $error("snoop hit and load request in one result");

  // Load fields stay zero unless a load executed.
  a_load_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_load_r) |->
      (out_main_r == '0) && (out_scratch_r == '0) && (out_words_r == '0))
    else $error("load fields nonzero without a load request");

  // An accepted tick always occupies the execute stage next cycle.
  a_tick_enters_exec: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> s1_valid_r)
    else $error("accepted tick lost before execute");

  // The thread pointer stays within the thread count.
  a_tid_range: assert property (@(posedge clk) disable iff (!rst_n)
    current_thread_r <= tdps_pkg::tid_t'(TC - 1))
    else $error("thread pointer out of range");

  // A new pending result may only appear behind an executed tick.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without an executed tick");

endmodule

`default_nettype wire

FILE: dv/tdps_thread_monitor.sv
// Scoreboard for the threaded DMA program sequencer: watches both channels,
// predicts each tick's result and compares it with what the block returns.
// Depends on tdps_pkg and the channel interfaces in tdps_if.
`timescale 1ns / 1ps

module tdps_thread_monitor (
  input  logic clk,
  input  logic rst_n,
  tdps_in_if   in_ch,
  tdps_out_if  out_ch,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic [tdps_pkg::SERVED_W-1:0] thread;
    tdps_pkg::word_t               pc;
    logic                          hit;
    logic                          load;
    tdps_pkg::word_t               main_addr;
    tdps_pkg::word_t               scratch_addr;
    logic [tdps_pkg::COUNT_W-1:0]  words;
  } tick_result_t;

  // Shadow copy of the sequencer state.
  tdps_pkg::tid_t                cur_thread;
  tdps_pkg::word_t               pc_of    [tdps_pkg::THREAD_COUNT];
  tdps_pkg::word_t               reg0_of  [tdps_pkg::THREAD_COUNT];
  tdps_pkg::word_t               reg1_of  [tdps_pkg::THREAD_COUNT];
  logic [tdps_pkg::TARGET_W-1:0] tgt0_of  [tdps_pkg::THREAD_COUNT];
  logic [tdps_pkg::TARGET_W-1:0] tgt1_of  [tdps_pkg::THREAD_COUNT];
  logic                          armed_of [tdps_pkg::THREAD_COUNT];
  tdps_pkg::word_t               program_copy [tdps_pkg::PROGRAM_DEPTH];

  tick_result_t        expected_ticks [$];

  task automatic clear_threads();
    cur_thread = '0;
    for (int i = 0; i < tdps_pkg::THREAD_COUNT; i++) begin
      pc_of[i]    = '0;
      reg0_of[i]  = '0;
      reg1_of[i]  = '0;
      tgt0_of[i]  = '0;
      tgt1_of[i]  = '0;
      armed_of[i] = 1'b0;
    end
  endtask

  // One tick: advance the thread pointer, then either snoop or execute.
  function automatic tick_result_t run_tick(tdps_pkg::word_t snoop_addr);
    tick_result_t    r;
    tdps_pkg::word_t inst;
    tdps_pkg::tid_t  t;
    r = '0;
    cur_thread = tdps_pkg::tid_t'((int'(cur_thread) + 1) % tdps_pkg::THREAD_COUNT);
    t = cur_thread;
    if (armed_of[t]) begin
      // Register 1 is compared first, so it wins when both match.
      if (snoop_addr == reg1_of[t]) begin
        pc_of[t]    = tdps_pkg::word_t'(tgt1_of[t]);
        armed_of[t] = 1'b0;
        r.hit       = 1'b1;
      end else if (snoop_addr == reg0_of[t]) begin
        pc_of[t]    = tdps_pkg::word_t'(tgt0_of[t]);
        armed_of[t] = 1'b0;
        r.hit       = 1'b1;
      end
    end else begin
      inst = program_copy[(pc_of[t] >> 2) % tdps_pkg::PROGRAM_DEPTH];
      case (tdps_pkg::opcode_t'(inst[31:30]))
        tdps_pkg::OP_SET_R0: reg0_of[t] = inst << 2;
        tdps_pkg::OP_SET_R1: reg1_of[t] = inst << 2;
        tdps_pkg::OP_LOAD: begin
          r.load         = 1'b1;
          r.words        = inst[tdps_pkg::COUNT_W-1:0];
          r.main_addr    = reg0_of[t];
          r.scratch_addr = reg1_of[t];
        end
        tdps_pkg::OP_SNOOP: begin
          tgt0_of[t]  = inst[29:15];
          tgt1_of[t]  = inst[14:0];
          armed_of[t] = 1'b1;
        end
        default: ;
      endcase
      pc_of[t] = pc_of[t] + 32'd4;
    end
    r.thread = tdps_pkg::SERVED_W'(t);
    r.pc     = pc_of[t];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    tick_result_t want;
    if (!rst_n) begin
      clear_threads();
      expected_ticks.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_ticks.size() == 0) begin
          $error("result transfer with no tick waiting for it");
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("thread_served", 32'(want.thread), 32'(out_ch.thread_served));
          check_field("next_pc", want.pc, out_ch.next_pc);
          check_field("snoop_hit", 32'(want.hit), 32'(out_ch.snoop_hit));
          check_field("load_request", 32'(want.load), 32'(out_ch.load_request));
          check_field("load_main_addr", want.main_addr, out_ch.load_main_addr);
          check_field("load_scratch_addr", want.scratch_addr, out_ch.load_scratch_addr);
          check_field("load_words", 32'(want.words), 32'(out_ch.load_words));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == tdps_pkg::MODE_WRITE) begin
          program_copy[int'(in_ch.prog_index) % tdps_pkg::PROGRAM_DEPTH] = in_ch.prog_word;
        end else begin
          expected_ticks.push_back(run_tick(in_ch.snoop_addr));
        end
      end
    end
    outstanding = expected_ticks.size();
  end

endmodule

FILE: dv/threaded_dma_program_sequencer_test.sv
// Top of the sequencer testbench: clock, reset, item and result traffic,
// watchdog and verdict. Predicting and checking live in tdps_thread_monitor.
// Depends on tdps_pkg, tdps_if, the sequencer RTL and tdps_thread_monitor.
`timescale 1ns / 1ps

module threaded_dma_program_sequencer_test;

  localparam int RANDOM_ITEMS   = 110;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  bit   steady;
  bit   hold_off_request;

  tdps_in_if  in_ch();
  tdps_out_if out_ch();

  threaded_dma_program_sequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tdps_thread_monitor i_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register values come from a small set of payloads, so snooped addresses
  // drawn from the same set hit often.
  function automatic logic [29:0] pool_payload(int k);
    case (k)
      0:       return 30'h0000_0000;
      1:       return 30'h3FFF_FFFF;
      2:       return 30'h1555_5555;
      3:       return 30'h2AAA_AAAA;
      4:       return 30'h0000_0001;
      5:       return 30'h2000_0000;
      6:       return 30'h0DEA_DBEE;
      default: return 30'h1234_5678;
    endcase
  endfunction

  function automatic tdps_pkg::word_t random_instruction();
    int                r;
    tdps_pkg::opcode_t op;
    logic [29:0]       body;
    r    = $urandom_range(99);
    body = 30'($urandom);
    if (r < 25)      op = tdps_pkg::OP_SET_R0;
    else if (r < 50) op = tdps_pkg::OP_SET_R1;
    else if (r < 78) op = tdps_pkg::OP_LOAD;
    else             op = tdps_pkg::OP_SNOOP;
    if ((op == tdps_pkg::OP_SET_R0 || op == tdps_pkg::OP_SET_R1) &&
        $urandom_range(99) < 80) begin
      body = pool_payload($urandom_range(7));
    end
    return {op, body};
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic mode, tdps_pkg::word_t snoop_addr,
                           logic [tdps_pkg::INDEX_W-1:0] idx, tdps_pkg::word_t word);
    // Each idle cycle is drawn on its own, with a chance of 30 in 100.
    while (!steady && $urandom_range(99) < 30) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.mode       = mode;
    in_ch.snoop_addr = snoop_addr;
    in_ch.prog_index = idx;
    in_ch.prog_word  = word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_tick(tdps_pkg::word_t snoop_addr);
    send_item(tdps_pkg::MODE_TICK, snoop_addr, tdps_pkg::INDEX_W'($urandom),
              tdps_pkg::word_t'($urandom));
  endtask

  task automatic send_write(logic [tdps_pkg::INDEX_W-1:0] idx, tdps_pkg::word_t word);
    send_item(tdps_pkg::MODE_WRITE, tdps_pkg::word_t'($urandom), idx, word);
  endtask

  initial begin : result_sink
    int hold_left;
    bit held;
    hold_left    = 0;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (steady) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int              r;
    tdps_pkg::word_t addr;
    rst_n            = 1'b0;
    steady           = 1'b0;
    hold_off_request = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = tdps_pkg::MODE_TICK;
    in_ch.snoop_addr = '0;
    in_ch.prog_index = '0;
    in_ch.prog_word  = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Fill the whole store first so that no fetch ever reads an unwritten word.
    for (int i = 0; i < tdps_pkg::PROGRAM_DEPTH; i++) begin
      send_write(tdps_pkg::INDEX_W'(i), random_instruction());
    end

    // Directed program, run by every thread in turn: arm a snoop, branch with
    // both registers matching, set register 1 to its top value, load the
    // largest count, arm again and then miss, hit register 0 and hit register 1.
    send_write(8'd0, {tdps_pkg::OP_SNOOP, 15'h7FFF, 15'd4});
    send_write(8'd1, {tdps_pkg::OP_SET_R1, 30'h3FFF_FFFF});
    send_write(8'd2, {tdps_pkg::OP_LOAD, 22'h0, 8'hFF});
    send_write(8'd3, {tdps_pkg::OP_SNOOP, 15'h7FFF, 15'h0000});
    for (int round = 0; round < 6; round++) begin
      for (int k = 0; k < tdps_pkg::THREAD_COUNT; k++) begin
        if (round == 1) addr = 32'h0000_0000;
        else if (round == 5) begin
          case (k % 3)
            0:       addr = 32'h1234_5678;
            1:       addr = 32'h0000_0000;
            default: addr = 32'hFFFF_FFFC;
          endcase
        end else addr = tdps_pkg::word_t'($urandom);
        send_tick(addr);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 20) hold_off_request = 1'b1;
      if (n == 40) steady = 1'b1;
      if (n == 100) steady = 1'b0;
      if ($urandom_range(99) < 15) begin
        send_write(tdps_pkg::INDEX_W'($urandom), random_instruction());
      end else begin
        r = $urandom_range(99);
        if (r < 50)      addr = {pool_payload($urandom_range(7)), 2'b00};
        else if (r < 55) addr = 32'hFFFF_FFFF;
        else             addr = tdps_pkg::word_t'($urandom);
        send_tick(addr);
      end
    end
    in_ch.valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
